[rtl/rkpc_pkg.sv]
// Shared constants and types for the RSA key parameter check unit.
package rkpc_pkg;

  localparam int unsigned PrimeWidthDef = 32;
  localparam int unsigned ExpWidth      = 64;
  localparam int unsigned DivWidth      = 64;

  // Control bundle from the sequencer to the shared divider.
  typedef struct packed {
    logic                start;
    logic [DivWidth-1:0] dividend;
    logic [DivWidth-1:0] divisor;
  } div_req_t;

  // Status bundle from the shared divider back to the sequencer.
  typedef struct packed {
    logic                done;
    logic [DivWidth-1:0] remainder;
  } div_rsp_t;

endpackage

[rtl/rkpc_divider.sv]
// Shared restoring divider: one remainder bit per cycle.
module rkpc_divider
  import rkpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DivWidth + 1);

  logic [DivWidth-1:0] rem_q, rem_d;
  logic [DivWidth-1:0] quo_q, quo_d;
  logic [DivWidth-1:0] den_q, den_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivWidth:0]   shifted;
  logic [DivWidth:0]   diff;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[DivWidth-1]};
    diff    = shifted - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = CntW'(DivWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DivWidth-2:0], 1'b0};
      if (!diff[DivWidth]) begin
        rem_d = diff[DivWidth-1:0];
      end else begin
        rem_d = shifted[DivWidth-1:0];
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

[rtl/rkpc_sequencer.sv]
// Sequencer: root, trial division, products and Euclid steps over the shared divider.
module rkpc_sequencer
  import rkpc_pkg::*;
#(
  parameter int unsigned PrimeWidth = PrimeWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [PrimeWidth-1:0] p_i,
  input  logic [PrimeWidth-1:0] q_i,
  input  logic [ExpWidth-1:0]   e_i,
  input  logic                  out_ready_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic                  p_prime_o,
  output logic                  q_prime_o,
  output logic [ExpWidth-1:0]   modulus_o,
  output logic [ExpWidth-1:0]   totient_o,
  output logic                  coprime_o,
  output div_req_t              div_req_o,
  input  div_rsp_t              div_rsp_i
);

  localparam int unsigned RootW = (PrimeWidth + 1) / 2;
  localparam int unsigned BitW  = $clog2(PrimeWidth + 1);

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StMulM  = 10'b0000000010,
    StMulT  = 10'b0000000100,
    StRoot  = 10'b0000001000,
    StTrial = 10'b0000010000,
    StWait  = 10'b0000100000,
    StNext  = 10'b0001000000,
    StGcd   = 10'b0010000000,
    StGwait = 10'b0100000000,
    StDone  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [PrimeWidth-1:0]   p_q, q_q, cand_q, cand_d;
  logic [ExpWidth-1:0]     e_q;
  logic [ExpWidth-1:0]     a_q, a_d, b_q, b_d;
  logic [ExpWidth-1:0]     mod_q, mod_d, tot_q, tot_d;
  logic [PrimeWidth-1:0]   rrem_q, rrem_d;
  logic [PrimeWidth-1:0]   rres_q, rres_d;
  logic [RootW-1:0]        div_q, div_d;
  logic [BitW-1:0]         rbit_q, rbit_d;
  logic                    which_q, which_d;
  logic                    pp_q, pp_d, qp_q, qp_d, cop_q, cop_d;
  logic [PrimeWidth-1:0]   mul_a, mul_b;
  logic [2*PrimeWidth-1:0] mul_p;
  logic [PrimeWidth:0]     rtry;
  logic [PrimeWidth-1:0]   rbitv;

  // One multiplier of candidate width, shared by the modulus and the totient.
  assign mul_a = (state_q == StMulT) ? (p_q - PrimeWidth'(1)) : p_q;
  assign mul_b = (state_q == StMulT) ? (q_q - PrimeWidth'(1)) : q_q;
  assign mul_p = {{PrimeWidth{1'b0}}, mul_a} * {{PrimeWidth{1'b0}}, mul_b};

  assign rbitv = PrimeWidth'(1) << rbit_q;
  assign rtry  = {1'b0, rres_q} + {1'b0, rbitv};

  always_comb begin
    state_d   = state_q;
    cand_d    = cand_q;
    a_d       = a_q;
    b_d       = b_q;
    mod_d     = mod_q;
    tot_d     = tot_q;
    rrem_d    = rrem_q;
    rres_d    = rres_q;
    div_d     = div_q;
    rbit_d    = rbit_q;
    which_d   = which_q;
    pp_d      = pp_q;
    qp_d      = qp_q;
    cop_d     = cop_q;
    div_req_o = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StMulM;
        end
      end
      // Two products through the one shared multiplier, one per cycle.
      StMulM: begin
        mod_d   = ExpWidth'(mul_p);
        state_d = StMulT;
      end
      // A zero candidate makes its factor all ones, so the product is negated.
      StMulT: begin
        if (p_q == '0 && q_q == '0) begin
          tot_d = ExpWidth'(1);
        end else if (p_q == '0) begin
          tot_d = ExpWidth'(1) - ExpWidth'(q_q);
        end else if (q_q == '0) begin
          tot_d = ExpWidth'(1) - ExpWidth'(p_q);
        end else begin
          tot_d = ExpWidth'(mul_p);
        end
        which_d = 1'b0;
        cand_d  = p_q;
        rrem_d  = p_q;
        rres_d  = '0;
        rbit_d  = BitW'(2 * (RootW - 1));
        state_d = StRoot;
      end
      // Digit-by-digit floor root, one digit per cycle.
      StRoot: begin
        if ({1'b0, rrem_q} >= rtry) begin
          rrem_d = rrem_q - rtry[PrimeWidth-1:0];
          rres_d = (rres_q >> 1) + rbitv;
        end else begin
          rres_d = rres_q >> 1;
        end
        if (rbit_q < BitW'(2)) begin
          state_d = StTrial;
          div_d   = ({1'b0, rrem_q} >= rtry) ? RootW'((rres_q >> 1) + rbitv)
                                             : RootW'(rres_q >> 1);
        end else begin
          rbit_d = rbit_q - BitW'(2);
        end
      end
      StTrial: begin
        if (cand_q < PrimeWidth'(2)) begin
          if (which_q) qp_d = 1'b0; else pp_d = 1'b0;
          state_d = StNext;
        end else if (div_q < RootW'(2)) begin
          if (which_q) qp_d = 1'b1; else pp_d = 1'b1;
          state_d = StNext;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = DivWidth'(cand_q);
          div_req_o.divisor  = DivWidth'(div_q);
          state_d            = StWait;
        end
      end
      StWait: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.remainder == '0) begin
            if (which_q) qp_d = 1'b0; else pp_d = 1'b0;
            state_d = StNext;
          end else begin
            div_d   = div_q - RootW'(1);
            state_d = StTrial;
          end
        end
      end
      StNext: begin
        if (!which_q) begin
          which_d = 1'b1;
          cand_d  = q_q;
          rrem_d  = q_q;
          rres_d  = '0;
          rbit_d  = BitW'(2 * (RootW - 1));
          state_d = StRoot;
        end else begin
          a_d     = e_q;
          b_d     = tot_q;
          state_d = StGcd;
        end
      end
      // Euclid: one remainder on the shared divider per step.
      StGcd: begin
        if (b_q == '0) begin
          cop_d   = (a_q == ExpWidth'(1));
          state_d = StDone;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = a_q;
          div_req_o.divisor  = b_q;
          state_d            = StGwait;
        end
      end
      StGwait: begin
        if (div_rsp_i.done) begin
          a_d     = b_q;
          b_d     = div_rsp_i.remainder;
          state_d = StGcd;
        end
      end
      // Hold the result until the output register takes it.
      StDone: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      p_q <= p_i;
      q_q <= q_i;
      e_q <= e_i;
    end
    cand_q  <= cand_d;
    a_q     <= a_d;
    b_q     <= b_d;
    mod_q   <= mod_d;
    tot_q   <= tot_d;
    rrem_q  <= rrem_d;
    rres_q  <= rres_d;
    div_q   <= div_d;
    rbit_q  <= rbit_d;
    which_q <= which_d;
    pp_q    <= pp_d;
    qp_q    <= qp_d;
    cop_q   <= cop_d;
  end

  assign busy_o    = (state_q != StIdle);
  assign done_o    = (state_q == StDone);
  assign p_prime_o = pp_q;
  assign q_prime_o = qp_q;
  assign modulus_o = mod_q;
  assign totient_o = tot_q;
  assign coprime_o = cop_q;

endmodule

[rtl/rsa_key_parameter_check_unit.sv]
// Top level of the RSA key parameter check unit.
//
// Usage: an item on the slave stream carries p, q and the exponent e. The
// block checks p and q for primality by trial division, forms n = p*q and
// the totient (p-1)*(q-1) mod 2^64, and tests gcd(e, totient) == 1. One
// result item per input item leaves on the master stream.
// Each trial divisor and each Euclid step costs one issue state plus one
// pass of the shared bit-serial divider; the divisors are tried from the
// floor root of each candidate downwards.
// Throughput: one item at a time; s_axis_tready is high only while the
// sequencer is idle.
// Reset clears the sequencer and the output valid; no item is held.
// A stalled receiver holds the result in the output register; the next
// item is accepted meanwhile, and its result waits until the register is
// taken.
module rsa_key_parameter_check_unit
  import rkpc_pkg::*;
#(
  parameter int unsigned PRIME_WIDTH = PrimeWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // prime_p[31:0], prime_q[63:32], exponent[127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata   // p_is_prime, q_is_prime, modulus[65:2],
                                      // totient[129:66], exponent_coprime[130], zeros
);

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                busy, done, pp, qp, cop;
  logic [ExpWidth-1:0] modulus, totient;
  logic                out_valid_q;
  logic [130:0]        out_data_q;
  logic                start;
  logic                hold;

  assign s_axis_tready = !busy && !(out_valid_q && done);
  assign start         = s_axis_tvalid && s_axis_tready;
  assign hold          = out_valid_q && !m_axis_tready;

  rkpc_sequencer #(.PrimeWidth(PRIME_WIDTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .p_i         (s_axis_tdata[PRIME_WIDTH-1:0]),
    .q_i         (s_axis_tdata[32 +: PRIME_WIDTH]),
    .e_i         (s_axis_tdata[127:64]),
    .out_ready_i (!hold),
    .busy_o      (busy),
    .done_o      (done),
    .p_prime_o   (pp),
    .q_prime_o   (qp),
    .modulus_o   (modulus),
    .totient_o   (totient),
    .coprime_o   (cop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  rkpc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register; the sequencer waits in its done state while it holds a stalled result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done && !hold) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && !hold) begin
      out_data_q <= {cop, totient, modulus, qp, pp};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_data_q};

endmodule

[rtl/rkpc_checker.sv]
// Port-level checker for the RSA key parameter check unit, with its bind.
module rkpc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  // A stalled result item keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The block never accepts two items in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted back to back");

  // The pad bits of the result are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[135:131] == 5'b0)
    else $error("pad bits set");

endmodule

bind rsa_key_parameter_check_unit rkpc_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
